// File: rtl/fpc_pkg.sv
// Types and constants shared by the flight phase classifier.
// Holds the phase, action and kind codes, register indexes, the word structs and magnitude helpers.
// No dependencies.
package fpc_pkg;

  typedef enum logic [2:0] {
    PH_UNKNOWN    = 3'd0,
    PH_LANDED     = 3'd1,
    PH_TAKING_OFF = 3'd2,
    PH_HOVERING   = 3'd3,
    PH_FLYING     = 3'd4,
    PH_LANDING    = 3'd5
  } phase_t;

  localparam logic [2:0] ACT_UNKNOWN  = 3'd0;
  localparam logic [2:0] ACT_TAKE_OFF = 3'd1;
  localparam logic [2:0] ACT_HOVER    = 3'd2;
  localparam logic [2:0] ACT_LAND     = 3'd3;
  localparam logic [2:0] ACT_MOVE     = 3'd4;

  localparam logic [2:0] REG_LINEAR_STILL  = 3'd0;
  localparam logic [2:0] REG_ANGULAR_STILL = 3'd1;
  localparam logic [2:0] REG_GROUND_ALT    = 3'd2;
  localparam logic [2:0] REG_AIRBORNE_ALT  = 3'd3;
  localparam logic [2:0] REG_TAKEOFF_DWELL = 3'd4;

  localparam logic KIND_ACTION = 1'b0;
  localparam logic KIND_SENSOR = 1'b1;

  typedef struct packed {
    logic [14:0] linear_still_limit;
    logic [14:0] angular_still_limit;
    logic [18:0] ground_altitude;
    logic [18:0] airborne_altitude;
    logic [31:0] takeoff_dwell;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_yaw;
    logic signed [19:0] altitude;
    logic        [31:0] time_ms;
  } sample_t;

  // Magnitude of a two's complement value; the most negative value maps to
  // its true magnitude because the result is read as unsigned.
  function automatic logic [15:0] mag16(logic signed [15:0] v);
    mag16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [19:0] mag20(logic signed [19:0] v);
    mag20 = v[19] ? 20'(-v) : 20'(v);
  endfunction

endpackage

// File: rtl/fpc_classify.sv
// Next-phase logic of the flight phase classifier for one sensor word.
// Purely combinational: threshold compares and the phase transition table.
// Depends on fpc_pkg.
module fpc_classify import fpc_pkg::*; (
  input  cfg_t        cfg,
  input  phase_t      phase,
  input  logic [2:0]  cmd_action,
  input  logic [31:0] takeoff_start,
  input  sample_t     sample,
  output phase_t      phase_next,
  output logic        start_load
);

  logic [15:0] axis_mag [6];
  logic [5:0]  still;
  logic [5:0]  moving;
  logic [15:0] lin_lim;
  logic [15:0] ang_lim;
  logic [19:0] alt_mag;
  logic        all_still;
  logic        any_moving;
  logic        above;
  logic        below;
  logic        vz_still;
  logic [31:0] elapsed;

  assign lin_lim = {1'b0, cfg.linear_still_limit};
  assign ang_lim = {1'b0, cfg.angular_still_limit};

  assign axis_mag[0] = mag16(sample.vel_x);
  assign axis_mag[1] = mag16(sample.vel_y);
  assign axis_mag[2] = mag16(sample.vel_z);
  assign axis_mag[3] = mag16(sample.rate_roll);
  assign axis_mag[4] = mag16(sample.rate_pitch);
  assign axis_mag[5] = mag16(sample.rate_yaw);

  // An axis exactly at its limit is neither still nor moving.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (i < 3) begin
        still[i]  = axis_mag[i] < lin_lim;
        moving[i] = axis_mag[i] > lin_lim;
      end else begin
        still[i]  = axis_mag[i] < ang_lim;
        moving[i] = axis_mag[i] > ang_lim;
      end
    end
  end

  assign all_still  = &still;
  assign any_moving = |moving;
  assign vz_still   = still[2];
  assign alt_mag    = mag20(sample.altitude);
  assign above      = alt_mag > {1'b0, cfg.ground_altitude};
  assign below      = alt_mag < {1'b0, cfg.ground_altitude};
  assign elapsed    = sample.time_ms - takeoff_start;

  always_comb begin
    phase_next = phase;
    start_load = 1'b0;
    case (cmd_action)
      ACT_TAKE_OFF: begin
        if (phase == PH_LANDED || phase == PH_UNKNOWN) begin
          phase_next = PH_TAKING_OFF;
          start_load = 1'b1;
        end else if (phase == PH_TAKING_OFF) begin
          if (vz_still && alt_mag > {1'b0, cfg.airborne_altitude} &&
              elapsed >= cfg.takeoff_dwell) begin
            phase_next = PH_FLYING;
          end
        end
      end
      ACT_HOVER: begin
        if (above && all_still) begin
          phase_next = PH_HOVERING;
        end
      end
      ACT_LAND: begin
        if (phase == PH_HOVERING || phase == PH_FLYING) begin
          if (sample.vel_z[15]) begin
            phase_next = PH_LANDING;
          end
        end else if (phase == PH_LANDING) begin
          if (below && vz_still) begin
            phase_next = PH_LANDED;
          end
        end
      end
      ACT_MOVE: begin
        if (above && any_moving) begin
          phase_next = PH_FLYING;
        end
        if (above && all_still) begin
          phase_next = PH_HOVERING;
        end
      end
      default: begin
        if (below && all_still) begin
          phase_next = PH_LANDED;
        end
        if (above && any_moving) begin
          phase_next = PH_FLYING;
        end
        if (above && all_still) begin
          phase_next = PH_HOVERING;
        end
      end
    endcase
  end

endmodule

// File: rtl/flight_phase_classifier.sv
// Top level of the flight phase classifier: input register, state, result register.
// Depends on fpc_pkg and fpc_classify.
//
// A word goes through two registers: it is captured in the input register, and when
// a sensor word leaves that register the phase logic updates the phase state and
// loads the result register, which drives the output. One word is taken every
// cycle while no result is held back; the phase register feeding back into the
// phase logic sets that figure. Action words update the stored command and give no
// result. A result that is not yet taken holds the result register; the input
// register then keeps the next sensor word and the block stops accepting words until
// the result is taken.
module flight_phase_classifier import fpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic [2:0]         action,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] vel_z,
  input  logic signed [15:0] rate_roll,
  input  logic signed [15:0] rate_pitch,
  input  logic signed [15:0] rate_yaw,
  input  logic signed [19:0] altitude,
  input  logic [31:0]        time_ms,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [2:0]         flight_phase,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t        cfg;
  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  cmd_action;
  logic [31:0] takeoff_start;
  logic        start_load;

  logic        s1_valid;
  logic        s1_kind;
  logic [2:0]  s1_action;
  sample_t     s1_sample;
  logic        s1_fire;
  logic        item_take;

  assign s1_fire    = s1_valid && (s1_kind == KIND_ACTION || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;
  assign item_take  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_still_limit  <= 15'd50;
      cfg.angular_still_limit <= 15'd50;
      cfg.ground_altitude     <= 19'd100;
      cfg.airborne_altitude   <= 19'd1000;
      cfg.takeoff_dwell       <= 32'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_STILL:  cfg.linear_still_limit  <= cfg_data[14:0];
        REG_ANGULAR_STILL: cfg.angular_still_limit <= cfg_data[14:0];
        REG_GROUND_ALT:    cfg.ground_altitude     <= cfg_data[18:0];
        REG_AIRBORNE_ALT:  cfg.airborne_altitude   <= cfg_data[18:0];
        REG_TAKEOFF_DWELL: cfg.takeoff_dwell       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_kind   <= kind;
      s1_action <= action;
      s1_sample <= '{vel_x: vel_x, vel_y: vel_y, vel_z: vel_z, rate_roll: rate_roll,
                     rate_pitch: rate_pitch, rate_yaw: rate_yaw, altitude: altitude,
                     time_ms: time_ms};
    end
  end

  fpc_classify u_classify (
    .cfg           (cfg),
    .phase         (phase),
    .cmd_action    (cmd_action),
    .takeoff_start (takeoff_start),
    .sample        (s1_sample),
    .phase_next    (phase_next),
    .start_load    (start_load)
  );

  // Phase state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_UNKNOWN;
      cmd_action    <= ACT_UNKNOWN;
      takeoff_start <= 32'd0;
      result_valid  <= 1'b0;
    end else begin
      if (s1_fire && s1_kind == KIND_ACTION) begin
        cmd_action <= s1_action;
      end
      if (s1_fire && s1_kind == KIND_SENSOR) begin
        phase        <= phase_next;
        result_valid <= 1'b1;
        if (start_load) begin
          takeoff_start <= s1_sample.time_ms;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_kind == KIND_SENSOR) begin
      flight_phase <= 3'(phase_next);
    end
  end

  // A word in the input register is never dropped without being processed.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid)
    else $error("input word lost");

  // Each new result carries the updated phase state.
  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_kind == KIND_SENSOR |=> result_valid && flight_phase == 3'(phase))
    else $error("result differs from phase state");

  // An action word never produces a result.
  a_action_silent: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_kind == KIND_ACTION |=> result_valid == $past(result_valid && !result_ready))
    else $error("action word produced a result");

  // The take-off start time moves only when a sensor word is processed.
  a_start_stable: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && s1_kind == KIND_SENSOR) |=> $stable(takeoff_start))
    else $error("take-off start changed without a sensor word");

  // Entering taking-off requires the take-off command.
  a_takeoff_cmd: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_kind == KIND_SENSOR && phase_next == PH_TAKING_OFF &&
    phase != PH_TAKING_OFF |-> cmd_action == ACT_TAKE_OFF)
    else $error("taking-off entered without take-off command");

endmodule

// File: sim/flight_phase_classifier_tb.sv
// Self-checking testbench for the flight phase classifier: random and directed words
// are checked against a phase predictor kept inside the bench.
// Depends on fpc_pkg and flight_phase_classifier.
module flight_phase_classifier_tb;
  import fpc_pkg::*;

  // Action code above move, handled like an unknown command.
  localparam logic [2:0] ACT_SPARE = 3'd7;

  localparam int ALT_LOW  = 0;
  localparam int ALT_MID  = 1;
  localparam int ALT_HIGH = 2;
  localparam int ALT_ANY  = 3;

  typedef struct packed {
    logic       kind;
    logic [2:0] action;
    sample_t    s;
  } word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic               kind;
  logic [2:0]         action;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic signed [15:0] rate_roll;
  logic signed [15:0] rate_pitch;
  logic signed [15:0] rate_yaw;
  logic signed [19:0] altitude;
  logic [31:0]        time_ms;
  logic               result_valid;
  logic               result_ready;
  logic [2:0]         flight_phase;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  // Mirror of the block's registers and state.
  logic [14:0] linear_limit;
  logic [14:0] angular_limit;
  logic [18:0] ground_alt;
  logic [18:0] airborne_alt;
  logic [31:0] dwell_ms;
  phase_t      cur_phase;
  logic [2:0]  cur_cmd;
  logic [31:0] climb_start;

  phase_t      expected_phases[$];
  int          errors = 0;
  int          idle_pct = 10;
  int          hold_len = 0;
  logic [31:0] clock_ms;

  flight_phase_classifier u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .action       (action),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .rate_roll    (rate_roll),
    .rate_pitch   (rate_pitch),
    .rate_yaw     (rate_yaw),
    .altitude     (altitude),
    .time_ms      (time_ms),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .flight_phase (flight_phase),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (errors < 50) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Updates the mirrored state for one accepted word and queues the phase it reports.
  function automatic void advance_phase(input word_t w);
    int          ax[6];
    int          alt_mag;
    int          lin_i = linear_limit;
    int          ang_i = angular_limit;
    int          gnd_i = ground_alt;
    int          air_i = airborne_alt;
    logic [31:0] elapsed;
    bit          all_still;
    bit          any_moving;
    bit          above;
    bit          below;
    bit          vz_still;
    if (w.kind == KIND_ACTION) begin
      cur_cmd = w.action;
      return;
    end
    ax[0] = magnitude($signed(w.s.vel_x));
    ax[1] = magnitude($signed(w.s.vel_y));
    ax[2] = magnitude($signed(w.s.vel_z));
    ax[3] = magnitude($signed(w.s.rate_roll));
    ax[4] = magnitude($signed(w.s.rate_pitch));
    ax[5] = magnitude($signed(w.s.rate_yaw));
    all_still = 1'b1;
    any_moving = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (ax[i] >= ((i < 3) ? lin_i : ang_i)) all_still = 1'b0;
      if (ax[i] > ((i < 3) ? lin_i : ang_i)) any_moving = 1'b1;
    end
    alt_mag = magnitude($signed(w.s.altitude));
    above = alt_mag > gnd_i;
    below = alt_mag < gnd_i;
    vz_still = ax[2] < lin_i;
    elapsed = w.s.time_ms - climb_start;
    case (cur_cmd)
      ACT_TAKE_OFF: begin
        if (cur_phase == PH_LANDED || cur_phase == PH_UNKNOWN) begin
          cur_phase = PH_TAKING_OFF;
          climb_start = w.s.time_ms;
        end else if (cur_phase == PH_TAKING_OFF) begin
          if (vz_still && alt_mag > air_i && elapsed >= dwell_ms) cur_phase = PH_FLYING;
        end
      end
      ACT_HOVER: begin
        if (above && all_still) cur_phase = PH_HOVERING;
      end
      ACT_LAND: begin
        if (cur_phase == PH_HOVERING || cur_phase == PH_FLYING) begin
          if ($signed(w.s.vel_z) < 0) cur_phase = PH_LANDING;
        end else if (cur_phase == PH_LANDING) begin
          if (below && vz_still) cur_phase = PH_LANDED;
        end
      end
      ACT_MOVE: begin
        if (above && any_moving) cur_phase = PH_FLYING;
        if (above && all_still) cur_phase = PH_HOVERING;
      end
      default: begin
        if (below && all_still) cur_phase = PH_LANDED;
        if (above && any_moving) cur_phase = PH_FLYING;
        if (above && all_still) cur_phase = PH_HOVERING;
      end
    endcase
    expected_phases.push_back(cur_phase);
  endfunction

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic send_word(input word_t w);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= w.kind;
    action     <= w.action;
    vel_x      <= w.s.vel_x;
    vel_y      <= w.s.vel_y;
    vel_z      <= w.s.vel_z;
    rate_roll  <= w.s.rate_roll;
    rate_pitch <= w.s.rate_pitch;
    rate_yaw   <= w.s.rate_yaw;
    altitude   <= w.s.altitude;
    time_ms    <= w.s.time_ms;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    advance_phase(w);
  endtask

  task automatic send_command(input logic [2:0] code);
    word_t w;
    w = word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.kind = KIND_ACTION;
    w.action = code;
    send_word(w);
  endtask

  task automatic send_sensor(input int vx, input int vy, input int vz, input int rr,
                             input int rp, input int ry, input int alt,
                             input logic [31:0] t);
    word_t w;
    w.kind = KIND_SENSOR;
    w.action = 3'($urandom);
    w.s.vel_x = 16'(vx);
    w.s.vel_y = 16'(vy);
    w.s.vel_z = 16'(vz);
    w.s.rate_roll = 16'(rr);
    w.s.rate_pitch = 16'(rp);
    w.s.rate_yaw = 16'(ry);
    w.s.altitude = 20'(alt);
    w.s.time_ms = t;
    send_word(w);
  endtask

  task automatic send_noise();
    word_t w;
    w = word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    send_word(w);
  endtask

  // Axis value that is mostly still when calm, otherwise near the limit, far past it or random.
  function automatic logic signed [15:0] axis_value(input int lim, input bit calm);
    int v;
    if (calm && $urandom_range(9) != 0) begin
      v = (lim == 0) ? 0 : $urandom_range(lim - 1);
    end else begin
      case ($urandom_range(6))
        0: v = lim;
        1: v = lim + 1;
        2: v = (lim > 0) ? lim - 1 : 0;
        3: v = 32768;
        4: v = $urandom_range(32767);
        default: v = $urandom_range(lim + 200);
      endcase
    end
    if ($urandom_range(1)) v = -v;
    return 16'(v);
  endfunction

  function automatic logic signed [19:0] alt_value(input int mode);
    int g;
    int a;
    int v;
    g = ground_alt;
    a = airborne_alt;
    case (mode)
      ALT_LOW:  v = (g == 0) ? 0 : $urandom_range(g - 1);
      ALT_MID:  v = (a > g) ? $urandom_range(a, g + 1) : g + 1;
      ALT_HIGH: v = $urandom_range(a + 3001, a + 1);
      default: begin
        case ($urandom_range(7))
          0: v = g;
          1: v = g + 1;
          2: v = g - 1;
          3: v = a;
          4: v = a + 1;
          5: v = 524288;
          6: v = 524287;
          default: v = $urandom_range(524287);
        endcase
      end
    endcase
    if (v > 524288) v = 524288;
    if ($urandom_range(1)) v = -v;
    return 20'(v);
  endfunction

  task automatic send_sample(input bit calm, input int alt_mode, input bit descend,
                             input logic [31:0] advance);
    word_t w;
    clock_ms += advance;
    w.kind = KIND_SENSOR;
    w.action = 3'($urandom);
    w.s.vel_x = axis_value(linear_limit, calm);
    w.s.vel_y = axis_value(linear_limit, calm);
    w.s.vel_z = descend ? 16'(-int'($urandom_range(3000, 1))) : axis_value(linear_limit, calm);
    w.s.rate_roll = axis_value(angular_limit, calm);
    w.s.rate_pitch = axis_value(angular_limit, calm);
    w.s.rate_yaw = axis_value(angular_limit, calm);
    w.s.altitude = alt_value(alt_mode);
    w.s.time_ms = clock_ms;
    send_word(w);
  endtask

  // Random flight from the ground: take-off, hover, move, land, at times an unknown command.
  task automatic fly_mission();
    logic [31:0] hop;
    hop = (dwell_ms >> 2) + 32'($urandom_range(40));
    send_command(ACT_TAKE_OFF);
    send_sample(1'b1, ALT_LOW, 1'b0, 32'($urandom_range(30)));
    repeat ($urandom_range(6, 2)) begin
      send_sample($urandom_range(4) != 0, ($urandom_range(3) == 0) ? ALT_ANY : ALT_HIGH,
                  1'b0, hop);
    end
    if ($urandom_range(4) == 0) send_noise();
    send_command(ACT_HOVER);
    repeat ($urandom_range(3, 1)) begin
      send_sample($urandom_range(4) != 0, ALT_MID, 1'b0, 32'($urandom_range(50)));
    end
    send_command(ACT_MOVE);
    repeat ($urandom_range(4, 1)) begin
      send_sample($urandom_range(1), ($urandom_range(2) == 0) ? ALT_ANY : ALT_MID, 1'b0,
                  32'($urandom_range(50)));
    end
    send_command(ACT_LAND);
    send_sample(1'b0, ALT_MID, 1'b1, 32'($urandom_range(50)));
    repeat ($urandom_range(3, 1)) begin
      send_sample($urandom_range(5) != 0, ($urandom_range(4) == 0) ? ALT_ANY : ALT_LOW,
                  1'b0, 32'($urandom_range(50)));
    end
    if ($urandom_range(2) == 0) begin
      send_command($urandom_range(1) ? ACT_UNKNOWN : 3'($urandom_range(ACT_SPARE, ACT_MOVE + 1)));
      send_sample($urandom_range(3) != 0, ALT_ANY, 1'b0, 32'($urandom_range(50)));
    end
  endtask

  // Leaves cfg_we high; the caller lowers it after its last register.
  task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LINEAR_STILL:  linear_limit = data[14:0];
      REG_ANGULAR_STILL: angular_limit = data[14:0];
      REG_GROUND_ALT:    ground_alt = data[18:0];
      REG_AIRBORNE_ALT:  airborne_alt = data[18:0];
      REG_TAKEOFF_DWELL: dwell_ms = data;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [31:0] lin, input logic [31:0] ang,
                                input logic [31:0] gnd, input logic [31:0] air,
                                input logic [31:0] dw);
    put_reg(REG_LINEAR_STILL, lin);
    put_reg(REG_ANGULAR_STILL, ang);
    put_reg(REG_GROUND_ALT, gnd);
    put_reg(REG_AIRBORNE_ALT, air);
    put_reg(REG_TAKEOFF_DWELL, dw);
    // Indexes past the last register must leave every setting alone.
    put_reg(3'($urandom_range(ACT_SPARE, REG_TAKEOFF_DWELL + 1)), $urandom);
    cfg_we <= 1'b0;
  endtask

  // Stops sending, waits for every queued phase, then lets the pipeline empty.
  task automatic settle();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (expected_phases.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_phases.size() != 0) begin
      report_mismatch($sformatf("%0d expected phases never arrived", expected_phases.size()));
      expected_phases.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sensor(0, 0, 0, 0, 0, 0, 0, 32'd10);
    send_sensor(0, 0, 0, 0, 0, 0, 100, 32'd11);
    send_command(ACT_TAKE_OFF);
    send_sensor(0, 0, 300, 0, 0, 0, 50, 32'd1000);
    send_sensor(0, 0, 49, 0, 0, 0, 1001, 32'd5999);
    send_sensor(0, 0, 50, 0, 0, 0, 2000, 32'd6000);
    send_sensor(0, 0, -49, 0, 0, 0, 1000, 32'd6000);
    send_sensor(0, 0, -49, 0, 0, 0, -1001, 32'd6000);
    send_command(ACT_HOVER);
    send_sensor(49, -49, 0, 49, -49, 49, 500, 32'd6100);
    send_command(ACT_LAND);
    send_sensor(0, 0, 0, 0, 0, 0, 500, 32'd6200);
    send_sensor(0, 0, -1, 0, 0, 0, 500, 32'd6300);
    send_sensor(0, 0, -49, 0, 0, 0, 100, 32'd6400);
    send_sensor(0, 0, -49, 0, 0, 0, 99, 32'd6500);
    send_command(ACT_MOVE);
    send_sensor(51, 0, 0, 0, 0, 0, 101, 32'd6600);
    send_sensor(0, 0, 0, 0, 0, 0, 101, 32'd6700);
    send_sensor(0, 0, 0, 0, 0, -50, 101, 32'd6800);
    send_command(ACT_SPARE);
    send_sensor(0, 0, 0, 0, 0, 0, -99, 32'd6900);
    send_sensor(-32768, 32767, 0, 0, 0, -32768, -524288, 32'hFFFF_FFFF);
    send_sensor(0, 0, 0, 0, 0, 0, 524287, 32'd0);
    // Take-off whose dwell is measured across the counter wrap.
    send_sensor(0, 0, 0, 0, 0, 0, 0, 32'd7000);
    send_command(ACT_TAKE_OFF);
    send_sensor(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
    send_sensor(0, 0, 0, 0, 0, 0, 2000, 32'h0000_1288);
    settle();
  endtask

  task automatic test_settings_sweep();
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: write_settings(32'd50, 32'd50, 32'd100, 32'd1000, 32'd5000);
        1: write_settings({17'($urandom), 15'd3}, {17'($urandom), 15'd2}, 32'd8, 32'd30,
                          32'd40);
        2: write_settings('0, '0, '0, '0, '0);
        3: write_settings('1, '1, '1, '1, '1);
        default: write_settings($urandom_range(400), $urandom_range(400),
                                $urandom_range(3000), $urandom_range(9000, 3000),
                                $urandom_range(20000));
      endcase
      repeat (20) fly_mission();
      repeat (40) send_noise();
      settle();
    end
  endtask

  task automatic test_full_rate();
    write_settings($urandom_range(200), $urandom_range(200), $urandom_range(500),
                   $urandom_range(3000, 500), $urandom_range(2000));
    idle_pct = 0;
    repeat (20) fly_mission();
    idle_pct = 10;
    settle();
  endtask

  task automatic test_output_stall();
    idle_pct = 0;
    hold_len = 120;
    repeat (40) send_noise();
    repeat (3) fly_mission();
    idle_pct = 10;
    settle();
  endtask

  task automatic test_pause_for_results();
    repeat (3) begin
      repeat (12) send_noise();
      settle();
    end
  endtask

  always @(posedge clk) begin
    phase_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_phases.size() == 0) begin
        report_mismatch($sformatf("phase %0d given with none expected", flight_phase));
      end else begin
        want = expected_phases.pop_front();
        if (flight_phase !== want) begin
          report_mismatch($sformatf("flight_phase %0d, expected %0d", flight_phase, want));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        result_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        result_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    kind       <= KIND_ACTION;
    action     <= ACT_UNKNOWN;
    vel_x      <= '0;
    vel_y      <= '0;
    vel_z      <= '0;
    rate_roll  <= '0;
    rate_pitch <= '0;
    rate_yaw   <= '0;
    altitude   <= '0;
    time_ms    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_LINEAR_STILL;
    cfg_data   <= '0;
    linear_limit  = 15'd50;
    angular_limit = 15'd50;
    ground_alt    = 19'd100;
    airborne_alt  = 19'd1000;
    dwell_ms      = 32'd5000;
    cur_phase     = PH_UNKNOWN;
    cur_cmd       = ACT_UNKNOWN;
    climb_start   = '0;
    clock_ms      = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings_sweep();
    test_full_rate();
    test_output_stall();
    test_pause_for_results();
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fpc_pkg.sv
rtl/fpc_classify.sv
rtl/flight_phase_classifier.sv
sim/flight_phase_classifier_tb.sv
